// ----- sv/pcls_pkg.sv -----
// Shared types, tag codes and constants for the per-class latency statistics block.
// Depends on nothing; every other file takes its names by package scope.
package pcls_pkg;

	localparam int TIME_WIDTH_DEF = 64;
	localparam int COUNT_W        = 64;
	localparam int AVG_W          = 16;
	localparam int NUM_CLASSES    = 6;
	localparam int CLASS_IDX_W    = 3;

	localparam logic [AVG_W-1:0] AVG_SAT_MAX = 16'hFFFF;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [7:0] TAG_BIND   = 8'h60;
	localparam logic [7:0] TAG_UNBIND = 8'h42;
	localparam logic [7:0] TAG_SEARCH = 8'h63;
	localparam logic [7:0] TAG_MODIFY = 8'h66;
	localparam logic [7:0] TAG_ADD    = 8'h68;
	localparam logic [7:0] TAG_DELETE = 8'h4A;

	localparam logic [CLASS_IDX_W-1:0] CLS_BIND   = 3'd0;
	localparam logic [CLASS_IDX_W-1:0] CLS_UNBIND = 3'd1;
	localparam logic [CLASS_IDX_W-1:0] CLS_SEARCH = 3'd2;
	localparam logic [CLASS_IDX_W-1:0] CLS_MODIFY = 3'd3;
	localparam logic [CLASS_IDX_W-1:0] CLS_ADD    = 3'd4;
	localparam logic [CLASS_IDX_W-1:0] CLS_DELETE = 3'd5;

	typedef struct packed {
		logic        op;
		logic [7:0]  request_tag;
		logic [63:0] elapsed_ms;
	} cmd_t;

	typedef struct packed {
		logic               known;
		logic [COUNT_W-1:0] sample_count;
		logic [AVG_W-1:0]   avg_ms;
		logic [COUNT_W-1:0] all_count;
	} res_t;

	typedef struct packed {
		logic                   hit;
		logic [CLASS_IDX_W-1:0] idx;
	} class_t;

	function automatic class_t class_of(input logic [7:0] tag);
		class_t c;
		c.hit = 1'b1;
		case (tag)
			TAG_BIND:   c.idx = CLS_BIND;
			TAG_UNBIND: c.idx = CLS_UNBIND;
			TAG_SEARCH: c.idx = CLS_SEARCH;
			TAG_MODIFY: c.idx = CLS_MODIFY;
			TAG_ADD:    c.idx = CLS_ADD;
			TAG_DELETE: c.idx = CLS_DELETE;
			default: begin
				c.hit = 1'b0;
				c.idx = CLS_BIND;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- sv/pcls_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pcls_pkg for default widths only.
module pcls_div #(
	parameter int NUM_W = pcls_pkg::TIME_WIDTH_DEF,
	parameter int DEN_W = pcls_pkg::COUNT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam logic [CW-1:0] LAST = CW'(NUM_W - 1);

	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quot_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// remainder stays below the divisor, so the shifted trial fits DEN_W+1 bits
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			quot_q <= num;
		end else if (run_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- sv/per_class_latency_statistics.sv -----
// Top level: class decode, per-class statistics stores, sequencer and result register.
// Depends on pcls_pkg and pcls_div.
//
//  channel   handshake           payload         direction
//  command   start / busy        cmd (cmd_t)     in
//  result    done (one cycle)    res (res_t)     out
//
// A known tag passes from accept through the update state, the load state and
// the shared divider, and its result is registered before the next accept.
// An unknown tag or an empty window skips the divider.
// Reset clears all six classes at once. The result strobe cannot be held off.
module per_class_latency_statistics #(
	parameter int TIME_WIDTH = pcls_pkg::TIME_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pcls_pkg::cmd_t      cmd,
	output logic                done,
	output pcls_pkg::res_t      res
);

	localparam int NC  = pcls_pkg::NUM_CLASSES;
	localparam int CNW = pcls_pkg::COUNT_W;
	localparam logic [63:0] TMASK = 64'((65'd1 << TIME_WIDTH) - 65'd1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_UPDATE = 2'd1;
	localparam logic [1:0] S_LOAD   = 2'd2;
	localparam logic [1:0] S_DIV    = 2'd3;

	logic [1:0]            state_q;
	logic                  done_q;
	pcls_pkg::class_t      cls_q;
	logic                  op_q;
	logic [TIME_WIDTH-1:0] t_q;
	pcls_pkg::res_t        res_q;

	logic [TIME_WIDTH-1:0] total_q [NC];
	logic [CNW-1:0]        win_q   [NC];
	logic [CNW-1:0]        life_q  [NC];

	logic                  accept;
	pcls_pkg::class_t      cls_in;
	logic [63:0]           t_nz;
	logic [63:0]           t_sat;
	logic [TIME_WIDTH:0]   sum;
	logic                  div_start;
	logic                  div_done;
	logic [TIME_WIDTH-1:0] div_quot;
	logic [63:0]           quot64;
	logic [pcls_pkg::AVG_W-1:0] avg;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign cls_in = pcls_pkg::class_of(cmd.request_tag);

	// zero counts as one, and clamp to the total's range
	assign t_nz  = (cmd.elapsed_ms == 64'd0) ? 64'd1 : cmd.elapsed_ms;
	assign t_sat = (t_nz > TMASK) ? TMASK : t_nz;

	assign sum = {1'b0, total_q[cls_q.idx]} + {1'b0, t_q};

	assign div_start = (state_q == S_LOAD) && (win_q[cls_q.idx] != '0);

	assign quot64 = 64'(div_quot);
	assign avg    = (|quot64[63:pcls_pkg::AVG_W]) ? pcls_pkg::AVG_SAT_MAX
	                                              : quot64[pcls_pkg::AVG_W-1:0];

	pcls_div #(
		.NUM_W(TIME_WIDTH),
		.DEN_W(CNW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (total_q[cls_q.idx]),
		.den   (win_q[cls_q.idx]),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cls_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cls_q   <= cls_in;
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (cls_q.hit) begin
						state_q <= S_LOAD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// statistics stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				total_q[i] <= '0;
				win_q[i]   <= '0;
				life_q[i]  <= '0;
			end
		end else if (state_q == S_UPDATE && cls_q.hit && op_q == pcls_pkg::OP_RECORD) begin
			life_q[cls_q.idx] <= life_q[cls_q.idx] + CNW'(1);
			if (sum[TIME_WIDTH]) begin
				// total wrapped: restart the window at this sample
				total_q[cls_q.idx] <= t_q;
				win_q[cls_q.idx]   <= CNW'(1);
			end else begin
				total_q[cls_q.idx] <= sum[TIME_WIDTH-1:0];
				win_q[cls_q.idx]   <= win_q[cls_q.idx] + CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd.op;
			t_q  <= t_sat[TIME_WIDTH-1:0];
		end
		if (state_q == S_UPDATE && !cls_q.hit) begin
			res_q <= '0;
		end else if (state_q == S_LOAD && !div_start) begin
			res_q.known        <= 1'b1;
			res_q.sample_count <= win_q[cls_q.idx];
			res_q.avg_ms       <= '0;
			res_q.all_count    <= life_q[cls_q.idx];
		end else if (state_q == S_DIV && div_done) begin
			res_q.known        <= 1'b1;
			res_q.sample_count <= win_q[cls_q.idx];
			res_q.avg_ms       <= avg;
			res_q.all_count    <= life_q[cls_q.idx];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- sv/pcls_checker.sv -----
// Port-level checks for per_class_latency_statistics, bound onto the top level.
// Depends on pcls_pkg for the payload types.
module pcls_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input pcls_pkg::cmd_t cmd,
	input logic           done,
	input pcls_pkg::res_t res
);

	// the block is always busy in the cycle after it accepts a word
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.known) |->
			(res.sample_count == '0 && res.avg_ms == '0 && res.all_count == '0))
		else $error("unknown tag result carries nonzero statistics");

	a_empty_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.sample_count == '0) |-> (res.avg_ms == '0))
		else $error("nonzero average on an empty window");

endmodule

bind per_class_latency_statistics pcls_checker u_pcls_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.res   (res)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for per_class_latency_statistics: directed and random record/query words,
// checked against a per-class statistics book kept in a small scoreboard class.
// Depends on pcls_pkg and the per_class_latency_statistics RTL.
module tb;

	localparam int TW              = pcls_pkg::TIME_WIDTH_DEF;
	localparam int NCL             = pcls_pkg::NUM_CLASSES;
	localparam int CW              = pcls_pkg::COUNT_W;
	localparam int WATCHDOG_MAX    = 4000;
	localparam int ITEMS_PER_PHASE = 400;

	class class_stats_book;
		logic [TW-1:0]      total_ms [NCL];
		logic [CW-1:0]      window_n [NCL];
		logic [CW-1:0]      lifetime_n [NCL];
		pcls_pkg::res_t     expected_results [$];
		int                 errors;
		int                 records;
		int                 queries;
		int                 unknown_tags;
		int                 window_restarts;

		function new();
			for (int i = 0; i < NCL; i++) begin
				total_ms[i]   = '0;
				window_n[i]   = '0;
				lifetime_n[i] = '0;
			end
			errors          = 0;
			records         = 0;
			queries         = 0;
			unknown_tags    = 0;
			window_restarts = 0;
		endfunction

		function bit slot_for(input logic [7:0] tag, output int idx);
			bit hit;
			hit = 1'b1;
			idx = 0;
			case (tag)
				pcls_pkg::TAG_BIND:   idx = 0;
				pcls_pkg::TAG_UNBIND: idx = 1;
				pcls_pkg::TAG_SEARCH: idx = 2;
				pcls_pkg::TAG_MODIFY: idx = 3;
				pcls_pkg::TAG_ADD:    idx = 4;
				pcls_pkg::TAG_DELETE: idx = 5;
				default:              hit = 1'b0;
			endcase
			return hit;
		endfunction

		function void note_command(input pcls_pkg::cmd_t c);
			pcls_pkg::res_t r;
			int             idx;
			logic [TW-1:0]  t;
			logic [TW-1:0]  sum;
			logic [63:0]    q;
			r = '0;
			if (!slot_for(c.request_tag, idx)) begin
				unknown_tags++;
				expected_results.push_back(r);
				return;
			end
			if (c.op == pcls_pkg::OP_RECORD) begin
				records++;
				// zero counts as one; wider than TW saturates
				t = (c.elapsed_ms == 64'd0) ? TW'(1) : TW'(c.elapsed_ms);
				if (TW < 64 && (c.elapsed_ms >> TW) != 64'd0)
					t = '1;
				lifetime_n[idx] = lifetime_n[idx] + 1'b1;
				sum = total_ms[idx] + t;
				if (sum < total_ms[idx]) begin
					total_ms[idx] = t;
					window_n[idx] = 64'd1;
					window_restarts++;
				end else begin
					total_ms[idx] = sum;
					window_n[idx] = window_n[idx] + 1'b1;
				end
			end else begin
				queries++;
			end
			r.known        = 1'b1;
			r.sample_count = window_n[idx];
			r.all_count    = lifetime_n[idx];
			if (window_n[idx] != '0) begin
				q = 64'(total_ms[idx]) / window_n[idx];
				r.avg_ms = (q > 64'(pcls_pkg::AVG_SAT_MAX)) ? pcls_pkg::AVG_SAT_MAX
				                                            : q[pcls_pkg::AVG_W-1:0];
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(input pcls_pkg::res_t got);
			pcls_pkg::res_t want;
			if (expected_results.size() == 0) begin
				$display("%0t ERROR unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.known !== want.known) begin
				$display("%0t ERROR known: expected %0d actual %0d",
					$time, want.known, got.known);
				errors++;
			end
			if (got.sample_count !== want.sample_count) begin
				$display("%0t ERROR sample_count: expected %0d actual %0d",
					$time, want.sample_count, got.sample_count);
				errors++;
			end
			if (got.avg_ms !== want.avg_ms) begin
				$display("%0t ERROR avg_ms: expected %0d actual %0d",
					$time, want.avg_ms, got.avg_ms);
				errors++;
			end
			if (got.all_count !== want.all_count) begin
				$display("%0t ERROR all_count: expected %0d actual %0d",
					$time, want.all_count, got.all_count);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	pcls_pkg::cmd_t cmd;
	logic           done;
	pcls_pkg::res_t res;

	class_stats_book book;
	int              idle_pct;
	int              quiet_cycles = 0;
	logic [7:0]      known_tags [NCL];

	per_class_latency_statistics dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// monitor: note accepted words, check every result strobe
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				book.note_command(cmd);
			if (done)
				book.check_result(res);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("%0t ERROR watchdog: no handshake for %0d cycles", $time, quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_word(input pcls_pkg::cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		// hold the word until the block takes it
		do @(posedge clk); while (busy);
	endtask

	task automatic send_fields(input logic op, input logic [7:0] tag, input logic [63:0] ms);
		pcls_pkg::cmd_t c;
		c.op          = op;
		c.request_tag = tag;
		c.elapsed_ms  = ms;
		send_word(c);
	endtask

	function automatic pcls_pkg::cmd_t random_word();
		pcls_pkg::cmd_t c;
		c.op = ($urandom_range(99) < 30) ? pcls_pkg::OP_QUERY : pcls_pkg::OP_RECORD;
		if ($urandom_range(99) < 80)
			c.request_tag = known_tags[$urandom_range(NCL - 1)];
		else
			c.request_tag = 8'($urandom_range(255));
		case ($urandom_range(9))
			0, 1, 2, 3: c.elapsed_ms = 64'($urandom_range(1000));
			4:          c.elapsed_ms = 64'($urandom_range(200000));
			5:          c.elapsed_ms = 64'd0;
			6, 7:       c.elapsed_ms = {$urandom, $urandom};
			8:          c.elapsed_ms = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
			default:    c.elapsed_ms = {32'd0, $urandom};
		endcase
		return c;
	endfunction

	initial begin
		book         = new();
		known_tags   = '{pcls_pkg::TAG_BIND, pcls_pkg::TAG_UNBIND, pcls_pkg::TAG_SEARCH,
		                 pcls_pkg::TAG_MODIFY, pcls_pkg::TAG_ADD, pcls_pkg::TAG_DELETE};
		idle_pct     = 13;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty class, unknown tags on both ops
		send_fields(pcls_pkg::OP_QUERY, pcls_pkg::TAG_BIND, 64'd0);
		send_fields(pcls_pkg::OP_QUERY, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
		send_fields(pcls_pkg::OP_RECORD, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
		// zero time per class, then a full-scale time that wraps the total
		for (int i = 0; i < NCL; i++)
			send_fields(pcls_pkg::OP_RECORD, known_tags[i], 64'd0);
		for (int i = 0; i < NCL; i++)
			send_fields(pcls_pkg::OP_RECORD, known_tags[i], 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < NCL; i++)
			send_fields(pcls_pkg::OP_QUERY, known_tags[i], 64'($urandom));
		send_fields(pcls_pkg::OP_RECORD, pcls_pkg::TAG_SEARCH, 64'd5);
		send_fields(pcls_pkg::OP_QUERY, pcls_pkg::TAG_SEARCH, 64'd0);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 13 : (phase == 1) ? 54 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_word(random_word());
		end
		@(negedge clk);
		start <= 1'b0;

		while (book.expected_results.size() != 0)
			@(posedge clk);
		// allow for a stray late strobe
		repeat (TW + 16) @(posedge clk);

		$display("covered %0d records, %0d queries, %0d unknown-tag words, %0d window restarts",
			book.records, book.queries, book.unknown_tags, book.window_restarts);
		if (book.errors == 0 && book.expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/pcls_pkg.sv
sv/pcls_div.sv
sv/per_class_latency_statistics.sv
sv/pcls_checker.sv
tb/tb.sv
